// File: hw/rtl/amgt_pkg.sv
// ----------------------------------------------------------------------------
// amgt_pkg
// Shared types, codes and helpers of the adjacency matrix graph core.
// ----------------------------------------------------------------------------
package amgt_pkg;

  localparam int MaxVerts = 32;
  localparam int VertW    = 5;
  localparam int CntW     = 6;

  localparam logic [2:0] OP_ADD_VERTEX = 3'd0;
  localparam logic [2:0] OP_DEL_VERTEX = 3'd1;
  localparam logic [2:0] OP_ADD_EDGE   = 3'd2;
  localparam logic [2:0] OP_DEL_EDGE   = 3'd3;
  localparam logic [2:0] OP_BFS        = 3'd4;
  localparam logic [2:0] OP_DFS        = 3'd5;
  localparam logic [2:0] OP_COMPONENTS = 3'd6;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD_VERTEX = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EDIT,
    CMD_BFS_INIT,
    CMD_DFS_INIT,
    CMD_COMP_INIT,
    CMD_BFS_POP,
    CMD_BFS_STEP,
    CMD_DFS_STEP,
    CMD_SEEK,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       trav_ok;
    logic       hit;
    logic       seek_hit;
    logic       queue_empty;
    logic       sp_one;
    logic       out_free;
  } sts_t;

  // Lowest set bit: {found, index}.
  function automatic logic [VertW:0] lowest_set(input logic [MaxVerts-1:0] v);
    logic [VertW:0] res;
    res = '0;
    for (int i = MaxVerts - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, VertW'(i)};
      end
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/adjacency_matrix_graph_traversal_core.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_traversal_core
// Undirected graph store with BFS, DFS and connected-component walks.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_axis_tready_o is high only while the core
// is idle. Edits answer with one beat, loaded into the output register from
// the decode state. A depth-first walk takes a step for each visit and one for
// each stack pop; a breadth-first walk also takes a step for each dequeue; a
// components run alternates seek steps with depth-first walks. Every step also
// waits while the output beat register is full and its beat is not taken.
module adjacency_matrix_graph_traversal_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // vertex_a[4:0], vertex_b[9:5], zero fill
  input  logic [2:0]  s_axis_tuser_i,   // op[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // visited_vertex[4:0], component_id[10:5],
                                        // tally[16:11], zero fill
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  output logic        m_axis_tlast_o
);
  import amgt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  amgt_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  amgt_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: hw/rtl/amgt_datapath.sv
// ----------------------------------------------------------------------------
// amgt_datapath
// Adjacency matrix, visited marks, queue, stack and result registers.
// ----------------------------------------------------------------------------
module amgt_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  amgt_pkg::ctl_t ctl_i,
  output amgt_pkg::sts_t sts_o,
  input  logic [15:0]    s_tdata_i,
  input  logic [2:0]     s_tuser_i,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [23:0]    m_tdata_o,
  output logic [1:0]     m_tuser_o,
  output logic           m_tlast_o
);
  import amgt_pkg::*;

  logic [MaxVerts-1:0] adj_q [MaxVerts];
  logic [MaxVerts-1:0] adj_d [MaxVerts];
  logic [CntW-1:0]     vt_q, cnt_q, head_q, tail_q, sp_q;
  logic [MaxVerts-1:0] visited_q;
  logic [VertW-1:0]    queue_q [MaxVerts];
  logic [VertW-1:0]    stack_q [MaxVerts];
  logic [VertW-1:0]    cur_q, a_q, b_q;
  logic [2:0]          op_q;
  logic                pend_v_q;
  logic [VertW-1:0]    pend_vtx_q;
  logic [CntW-1:0]     pend_comp_q;
  logic                out_v_q, out_last_q;
  logic [VertW-1:0]    out_vtx_q;
  logic [CntW-1:0]     out_comp_q, out_tally_q;
  logic [1:0]          out_st_q;

  logic [MaxVerts-1:0] lim_mask, row, cand, unvisited;
  logic [VertW:0]      hit_r, seek_r;
  logic                a_ok, b_ok, is_comp, out_free;
  logic [1:0]          e_status;
  logic [CntW-1:0]     e_vt;
  logic                do_rm, do_set, do_clr;
  logic                emit;
  logic [VertW-1:0]    emit_vtx;
  logic [CntW-1:0]     emit_comp;
  logic                out_load;

  always_comb begin
    for (int j = 0; j < MaxVerts; j++) begin
      lim_mask[j] = CntW'(j) < vt_q;
    end
  end

  assign row       = adj_q[cur_q];
  assign cand      = row & ~visited_q & lim_mask;
  assign unvisited = ~visited_q & lim_mask;
  assign hit_r     = lowest_set(cand);
  assign seek_r    = lowest_set(unvisited);
  assign a_ok      = {1'b0, a_q} < vt_q;
  assign b_ok      = {1'b0, b_q} < vt_q;
  assign is_comp   = op_q == OP_COMPONENTS;
  assign out_free  = !out_v_q || m_tready_i;

  always_comb begin
    e_status = ST_OK;
    e_vt     = vt_q;
    do_rm    = 1'b0;
    do_set   = 1'b0;
    do_clr   = 1'b0;
    unique case (op_q)
      OP_ADD_VERTEX: begin
        if (vt_q >= CntW'(MaxVerts)) e_status = ST_FULL_EMPTY;
        else e_vt = vt_q + CntW'(1);
      end
      OP_DEL_VERTEX: begin
        if (vt_q == '0) e_status = ST_FULL_EMPTY;
        else if (!a_ok) e_status = ST_BAD_VERTEX;
        else begin
          do_rm = 1'b1;
          e_vt  = vt_q - CntW'(1);
        end
      end
      OP_ADD_EDGE, OP_DEL_EDGE: begin
        if (!(a_ok && b_ok)) e_status = ST_BAD_VERTEX;
        else if (op_q == OP_ADD_EDGE) do_set = 1'b1;
        else do_clr = 1'b1;
      end
      OP_BFS, OP_DFS, OP_COMPONENTS: begin
        e_status = (vt_q == '0) ? ST_FULL_EMPTY : ST_BAD_VERTEX;
      end
      default: e_status = ST_OK;
    endcase
  end

  // Next value of every adjacency row for an edit command.
  always_comb begin
    for (int r = 0; r < MaxVerts; r++) begin
      adj_d[r] = adj_q[r];
      if (do_rm) begin
        if (VertW'(r) == a_q) adj_d[r] = '0;
        else adj_d[r][a_q] = 1'b0;
      end
      if (do_set) begin
        if (VertW'(r) == a_q) adj_d[r][b_q] = 1'b1;
        if (VertW'(r) == b_q) adj_d[r][a_q] = 1'b1;
      end
      if (do_clr) begin
        if (VertW'(r) == a_q) adj_d[r][b_q] = 1'b0;
        if (VertW'(r) == b_q) adj_d[r][a_q] = 1'b0;
      end
    end
  end

  // A new traversal result pushes the pending one out.
  always_comb begin
    emit      = 1'b0;
    emit_vtx  = hit_r[VertW-1:0];
    emit_comp = is_comp ? cnt_q : '0;
    unique case (ctl_i.cmd)
      CMD_BFS_STEP, CMD_DFS_STEP: emit = hit_r[VertW];
      CMD_SEEK: begin
        emit      = seek_r[VertW];
        emit_vtx  = seek_r[VertW-1:0];
        emit_comp = cnt_q + CntW'(1);
      end
      default: emit = 1'b0;
    endcase
  end

  assign out_load = (emit && pend_v_q) || ctl_i.cmd == CMD_EDIT || ctl_i.cmd == CMD_FINISH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxVerts; r++) adj_q[r] <= '0;
    end else if (ctl_i.cmd == CMD_EDIT) begin
      for (int r = 0; r < MaxVerts; r++) adj_q[r] <= adj_d[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CMD_BFS_INIT) queue_q[0] <= a_q;
    else if (ctl_i.cmd == CMD_BFS_STEP && hit_r[VertW]) queue_q[tail_q[VertW-1:0]] <= hit_r[VertW-1:0];
    if (ctl_i.cmd == CMD_DFS_INIT) stack_q[0] <= a_q;
    else if (ctl_i.cmd == CMD_SEEK && seek_r[VertW]) stack_q[0] <= seek_r[VertW-1:0];
    else if (ctl_i.cmd == CMD_DFS_STEP && hit_r[VertW]) stack_q[sp_q[VertW-1:0]] <= hit_r[VertW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q        <= '0;
      cnt_q       <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      sp_q        <= '0;
      cur_q       <= '0;
      op_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      pend_v_q    <= 1'b0;
      pend_vtx_q  <= '0;
      pend_comp_q <= '0;
      out_v_q     <= 1'b0;
      out_vtx_q   <= '0;
      out_comp_q  <= '0;
      out_tally_q <= '0;
      out_st_q    <= ST_OK;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (m_tready_i) out_v_q <= 1'b0;
      if (emit) begin
        visited_q   <= visited_q | (MaxVerts'(1) << emit_vtx);
        pend_v_q    <= 1'b1;
        pend_vtx_q  <= emit_vtx;
        pend_comp_q <= emit_comp;
        if (pend_v_q) begin
          out_vtx_q   <= pend_vtx_q;
          out_comp_q  <= pend_comp_q;
          out_tally_q <= '0;
          out_st_q    <= ST_OK;
          out_last_q  <= 1'b0;
        end
      end
      unique case (ctl_i.cmd)
        CMD_LOAD: begin
          op_q <= s_tuser_i;
          a_q  <= s_tdata_i[VertW-1:0];
          b_q  <= s_tdata_i[2*VertW-1:VertW];
        end
        CMD_EDIT: begin
          vt_q        <= e_vt;
          out_vtx_q   <= '0;
          out_comp_q  <= '0;
          out_tally_q <= e_vt;
          out_st_q    <= e_status;
          out_last_q  <= 1'b1;
        end
        CMD_BFS_INIT, CMD_DFS_INIT: begin
          visited_q   <= MaxVerts'(1) << a_q;
          pend_v_q    <= 1'b1;
          pend_vtx_q  <= a_q;
          pend_comp_q <= '0;
          head_q      <= '0;
          tail_q      <= CntW'(1);
          sp_q        <= CntW'(1);
          cur_q       <= a_q;
        end
        CMD_COMP_INIT: begin
          visited_q <= '0;
          cnt_q     <= '0;
          pend_v_q  <= 1'b0;
        end
        CMD_BFS_POP: begin
          cur_q  <= queue_q[head_q[VertW-1:0]];
          head_q <= head_q + CntW'(1);
        end
        CMD_BFS_STEP: begin
          if (hit_r[VertW]) tail_q <= tail_q + CntW'(1);
        end
        CMD_DFS_STEP: begin
          if (hit_r[VertW]) begin
            sp_q  <= sp_q + CntW'(1);
            cur_q <= hit_r[VertW-1:0];
          end else begin
            sp_q  <= sp_q - CntW'(1);
            cur_q <= stack_q[VertW'(sp_q - CntW'(2))];
          end
        end
        CMD_SEEK: begin
          if (seek_r[VertW]) begin
            cnt_q <= cnt_q + CntW'(1);
            sp_q  <= CntW'(1);
            cur_q <= seek_r[VertW-1:0];
          end
        end
        CMD_FINISH: begin
          pend_v_q    <= 1'b0;
          out_vtx_q   <= pend_vtx_q;
          out_comp_q  <= pend_comp_q;
          out_tally_q <= is_comp ? cnt_q : '0;
          out_st_q    <= ST_OK;
          out_last_q  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.op          = op_q;
  assign sts_o.trav_ok     = (vt_q != '0) && (is_comp || a_ok);
  assign sts_o.hit         = hit_r[VertW];
  assign sts_o.seek_hit    = seek_r[VertW];
  assign sts_o.queue_empty = head_q == tail_q;
  assign sts_o.sp_one      = sp_q == CntW'(1);
  assign sts_o.out_free    = out_free;

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {7'b0, out_tally_q, out_comp_q, out_vtx_q};
  assign m_tuser_o  = out_st_q;
  assign m_tlast_o  = out_last_q;

endmodule

// File: hw/rtl/amgt_controller.sv
// ----------------------------------------------------------------------------
// amgt_controller
// Command sequencer for edits and the three traversal walks.
// ----------------------------------------------------------------------------
module amgt_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  amgt_pkg::sts_t sts_i,
  output amgt_pkg::ctl_t ctl_o
);
  import amgt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_BFS_POP  = 3'd2;
  localparam logic [2:0] S_BFS_STEP = 3'd3;
  localparam logic [2:0] S_DFS      = 3'd4;
  localparam logic [2:0] S_SEEK     = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0] state_q, state_d;
  logic       is_trav;

  assign is_trav    = sts_i.op == OP_BFS || sts_i.op == OP_DFS || sts_i.op == OP_COMPONENTS;
  assign s_tready_o = state_q == S_IDLE;

  always_comb begin
    state_d   = state_q;
    ctl_o.cmd = CMD_NONE;
    // A step may write the result register; all but the accept wait until it is free.
    if (state_q == S_IDLE) begin
      if (s_tvalid_i) begin
        ctl_o.cmd = CMD_LOAD;
        state_d   = S_DECODE;
      end
    end else if (sts_i.out_free) begin
      unique case (state_q)
        S_DECODE: begin
          if (is_trav && sts_i.trav_ok) begin
            unique case (sts_i.op)
              OP_BFS: begin
                ctl_o.cmd = CMD_BFS_INIT;
                state_d   = S_BFS_POP;
              end
              OP_DFS: begin
                ctl_o.cmd = CMD_DFS_INIT;
                state_d   = S_DFS;
              end
              default: begin
                ctl_o.cmd = CMD_COMP_INIT;
                state_d   = S_SEEK;
              end
            endcase
          end else begin
            ctl_o.cmd = CMD_EDIT;
            state_d   = S_IDLE;
          end
        end
        S_BFS_POP: begin
          if (sts_i.queue_empty) begin
            state_d = S_FIN;
          end else begin
            ctl_o.cmd = CMD_BFS_POP;
            state_d   = S_BFS_STEP;
          end
        end
        S_BFS_STEP: begin
          ctl_o.cmd = CMD_BFS_STEP;
          if (!sts_i.hit) state_d = S_BFS_POP;
        end
        S_DFS: begin
          ctl_o.cmd = CMD_DFS_STEP;
          if (!sts_i.hit && sts_i.sp_one) begin
            state_d = (sts_i.op == OP_COMPONENTS) ? S_SEEK : S_FIN;
          end
        end
        S_SEEK: begin
          ctl_o.cmd = CMD_SEEK;
          state_d   = sts_i.seek_hit ? S_DFS : S_FIN;
        end
        S_FIN: begin
          ctl_o.cmd = CMD_FINISH;
          state_d   = S_IDLE;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/amgt_checker.sv
// ----------------------------------------------------------------------------
// amgt_checker
// Port-level checks of the graph traversal core.
// ----------------------------------------------------------------------------
module amgt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import amgt_pkg::*;

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // Only one command is in work at a time.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted while busy");

  // Traversal beats before the final one always report success.
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o == ST_OK)
    else $error("error status on a non-final beat");

  // An error is a single final beat with no vertex or component.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |->
      m_axis_tlast_o && m_axis_tdata_o[10:0] == 11'd0)
    else $error("malformed error beat");

endmodule

bind adjacency_matrix_graph_traversal_core amgt_checker u_amgt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// File: tb/adjacency_matrix_graph_traversal_core_test.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_traversal_core_test
// Self-checking bench for the graph core: a directed table of commands, then
// random graph edits and walks, all results checked against a built-in model.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_traversal_core_test;
  import amgt_pkg::*;

  typedef struct packed {
    logic [4:0] vert;
    logic [5:0] comp;
    logic [5:0] tally;
    logic [1:0] status;
    logic       last;
  } beat_t;

  typedef struct {
    logic [2:0] op;
    logic [4:0] a;
    logic [4:0] b;
    logic       has_exp;
    logic [5:0] exp_tally;
    logic [1:0] exp_status;
  } row_t;

  localparam int TimeoutCycles = 20000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  adjacency_matrix_graph_traversal_core u_dut (.*);

  // Mirror of the graph.
  logic [31:0] adj_rows [32];
  int unsigned vert_count;
  logic [31:0] seen;
  beat_t       pending_beats[$];
  int          mismatches;
  int          idle_cycles;
  bit          rx_stall_ok;

  function automatic beat_t mk(int v, int c, int t, logic [1:0] s, int l);
    beat_t r;
    r.vert = v[4:0];
    r.comp = c[5:0];
    r.tally = t[5:0];
    r.status = s;
    r.last = l[0];
    return r;
  endfunction

  function automatic int reach_limit();
    return vert_count < 32 ? vert_count : 32;
  endfunction

  function automatic void depth_walk(int start, int comp);
    int stk_v [32];
    int stk_n [32];
    int sp, v, w, lim;
    bit found;
    lim = reach_limit();
    seen[start] = 1'b1;
    pending_beats.push_back(mk(start, comp, 0, ST_OK, 0));
    stk_v[0] = start;
    stk_n[0] = 0;
    sp = 1;
    while (sp > 0) begin
      v = stk_v[sp-1];
      w = stk_n[sp-1];
      found = 0;
      while (w < lim && !found) begin
        if (adj_rows[v][w] && !seen[w]) found = 1;
        else w++;
      end
      if (found && sp < 32) begin
        stk_n[sp-1] = w + 1;
        seen[w] = 1'b1;
        pending_beats.push_back(mk(w, comp, 0, ST_OK, 0));
        stk_v[sp] = w;
        stk_n[sp] = 0;
        sp++;
      end else begin
        sp--;
      end
    end
  endfunction

  function automatic void breadth_walk(int start);
    int fifo [32];
    int head, tail, v, lim;
    lim = reach_limit();
    head = 0;
    tail = 0;
    seen[start] = 1'b1;
    pending_beats.push_back(mk(start, 0, 0, ST_OK, 0));
    fifo[tail++] = start;
    while (head < tail && head < 32) begin
      v = fifo[head++];
      for (int w = 0; w < lim; w++) begin
        if (adj_rows[v][w] && !seen[w]) begin
          seen[w] = 1'b1;
          pending_beats.push_back(mk(w, 0, 0, ST_OK, 0));
          if (tail < 32) fifo[tail++] = w;
        end
      end
    end
  endfunction

  function automatic void predict_command(logic [2:0] op, int a, int b);
    int comps;
    beat_t t;
    case (op)
      OP_ADD_VERTEX: begin
        if (vert_count >= MaxVerts) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_FULL_EMPTY, 1));
        end else begin
          vert_count++;
          pending_beats.push_back(mk(0, 0, vert_count, ST_OK, 1));
        end
      end
      OP_DEL_VERTEX: begin
        if (vert_count == 0) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_FULL_EMPTY, 1));
        end else if (a >= vert_count) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_BAD_VERTEX, 1));
        end else begin
          adj_rows[a] = '0;
          for (int i = 0; i < 32; i++) adj_rows[i][a] = 1'b0;
          vert_count--;
          pending_beats.push_back(mk(0, 0, vert_count, ST_OK, 1));
        end
      end
      OP_ADD_EDGE, OP_DEL_EDGE: begin
        if (a >= vert_count || b >= vert_count) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_BAD_VERTEX, 1));
        end else begin
          adj_rows[a][b] = (op == OP_ADD_EDGE);
          adj_rows[b][a] = (op == OP_ADD_EDGE);
          pending_beats.push_back(mk(0, 0, vert_count, ST_OK, 1));
        end
      end
      OP_BFS, OP_DFS: begin
        if (vert_count == 0) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_FULL_EMPTY, 1));
        end else if (a >= vert_count) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_BAD_VERTEX, 1));
        end else begin
          seen = '0;
          if (op == OP_BFS) breadth_walk(a);
          else depth_walk(a, 0);
          t = pending_beats.pop_back();
          t.last = 1'b1;
          pending_beats.push_back(t);
        end
      end
      OP_COMPONENTS: begin
        if (vert_count == 0) begin
          pending_beats.push_back(mk(0, 0, vert_count, ST_FULL_EMPTY, 1));
        end else begin
          seen = '0;
          comps = 0;
          for (int i = 0; i < reach_limit(); i++) begin
            if (!seen[i]) begin
              comps++;
              depth_walk(i, comps);
            end
          end
          t = pending_beats.pop_back();
          t.tally = comps[5:0];
          t.last = 1'b1;
          pending_beats.push_back(t);
        end
      end
      default: pending_beats.push_back(mk(0, 0, vert_count, ST_OK, 1));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int short_or_long_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The core is never ready in the cycle after an accept, so the extra falling
  // edge before driving costs no throughput.
  task automatic send_command(logic [2:0] op, logic [4:0] a, logic [4:0] b, bit gaps);
    int g;
    g = gaps ? short_or_long_gap() : 0;
    repeat (g + 1) @(negedge clk_i);
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'd0, b, a};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_command(op, int'(a), int'(b));
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 16'($urandom) & 16'h03ff;
  endtask

  // Result side: random backpressure, compare against the oldest expectation.
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = mk(int'(m_axis_tdata_o[4:0]), int'(m_axis_tdata_o[10:5]),
               int'(m_axis_tdata_o[16:11]), m_axis_tuser_o, int'(m_axis_tlast_o));
      if (pending_beats.size() == 0) begin
        $error("unexpected beat vert=%0d status=%0d", got.vert, got.status);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (got.vert !== want.vert) begin
          $error("visited_vertex: expected %0d, got %0d", want.vert, got.vert);
          mismatches++;
        end
        if (got.comp !== want.comp) begin
          $error("component_id: expected %0d, got %0d", want.comp, got.comp);
          mismatches++;
        end
        if (got.tally !== want.tally) begin
          $error("tally: expected %0d, got %0d", want.tally, got.tally);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int g;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = rx_stall_ok ? short_or_long_gap() : 0;
      if (g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= TimeoutCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  row_t directed [21] = '{
    '{OP_DEL_VERTEX, 5'd0,  5'd0,  1'b1, 6'd0, ST_FULL_EMPTY},
    '{OP_BFS,        5'd0,  5'd0,  1'b1, 6'd0, ST_FULL_EMPTY},
    '{OP_DFS,        5'd0,  5'd0,  1'b1, 6'd0, ST_FULL_EMPTY},
    '{OP_COMPONENTS, 5'd0,  5'd0,  1'b1, 6'd0, ST_FULL_EMPTY},
    '{OP_UNUSED,     5'd31, 5'd31, 1'b1, 6'd0, ST_OK},
    '{OP_ADD_VERTEX, 5'd0,  5'd0,  1'b1, 6'd1, ST_OK},
    '{OP_ADD_EDGE,   5'd0,  5'd1,  1'b1, 6'd1, ST_BAD_VERTEX},
    '{OP_ADD_EDGE,   5'd0,  5'd0,  1'b1, 6'd1, ST_OK},
    '{OP_DEL_VERTEX, 5'd31, 5'd0,  1'b1, 6'd1, ST_BAD_VERTEX},
    '{OP_BFS,        5'd31, 5'd0,  1'b1, 6'd1, ST_BAD_VERTEX},
    '{OP_ADD_VERTEX, 5'd0,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_ADD_VERTEX, 5'd0,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_ADD_EDGE,   5'd1,  5'd2,  1'b0, 6'd0, ST_OK},
    '{OP_BFS,        5'd2,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_DFS,        5'd0,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_COMPONENTS, 5'd0,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_DEL_EDGE,   5'd2,  5'd1,  1'b0, 6'd0, ST_OK},
    '{OP_DEL_EDGE,   5'd3,  5'd1,  1'b0, 6'd0, ST_OK},
    '{OP_DEL_VERTEX, 5'd1,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_ADD_VERTEX, 5'd0,  5'd0,  1'b0, 6'd0, ST_OK},
    '{OP_COMPONENTS, 5'd0,  5'd0,  1'b0, 6'd0, ST_OK}
  };

  initial begin
    int p, op_pick;
    logic [2:0] op;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    rst_ni          = 1'b0;
    mismatches      = 0;
    idle_cycles     = 0;
    rx_stall_ok     = 0;
    vert_count      = 0;
    seen            = '0;
    for (int i = 0; i < 32; i++) adj_rows[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows; where a value is typed in it replaces the prediction.
    // Such rows answer with one beat, which is still the newest expectation.
    foreach (directed[i]) begin
      send_command(directed[i].op, directed[i].a, directed[i].b, 1'b0);
      if (directed[i].has_exp) begin
        void'(pending_beats.pop_back());
        pending_beats.push_back(mk(0, 0, int'(directed[i].exp_tally),
                                   directed[i].exp_status, 1));
      end
    end
    rx_stall_ok = 1;

    // Fill to full, one extra add hits the full case.
    while (vert_count < MaxVerts) send_command(OP_ADD_VERTEX, 5'd0, 5'd0, 1'b1);
    send_command(OP_ADD_VERTEX, 5'h1f, 5'h1f, 1'b1);
    send_command(OP_ADD_EDGE, 5'd31, 5'd0, 1'b1);
    send_command(OP_COMPONENTS, 5'd0, 5'd0, 1'b1);

    // Sender holds off until every result is back.
    while (pending_beats.size() != 0) @(negedge clk_i);

    for (int k = 0; k < 375; k++) begin
      p = $urandom_range(0, 99);
      if (p < 45) op_pick = OP_ADD_EDGE;
      else if (p < 55) op_pick = OP_DEL_EDGE;
      else if (p < 63) op_pick = OP_ADD_VERTEX;
      else if (p < 70) op_pick = OP_DEL_VERTEX;
      else if (p < 80) op_pick = OP_BFS;
      else if (p < 90) op_pick = OP_DFS;
      else if (p < 97) op_pick = OP_COMPONENTS;
      else op_pick = $urandom_range(0, 7);
      op = op_pick[2:0];
      // Keep vertex numbers mostly valid; a few stray wide.
      if (vert_count > 0 && $urandom_range(0, 9) != 0)
        send_command(op, 5'($urandom_range(0, reach_limit() - 1)),
                     5'($urandom_range(0, reach_limit() - 1)), 1'b1);
      else
        send_command(op, 5'($urandom), 5'($urandom), 1'b1);
      // Keep the graph mid-sized so walks stay long.
      if (vert_count < 6) send_command(OP_ADD_VERTEX, 5'($urandom), 5'($urandom), 1'b1);
    end

    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
